### rtl/wrs_pkg.sv
// ----------------------------------------------------------------------------
// Water ripple stencil package
// Field widths, register map and reset values shared by the stencil core.
// ----------------------------------------------------------------------------
`default_nettype none

package wrs_pkg;

  // Cell height: signed Q11.8.
  localparam int HEIGHT_W = 20;
  typedef logic signed [HEIGHT_W-1:0] height_t;

  // Result fields.
  localparam int COORD_W      = 10;
  localparam int SHADE_W      = 8;
  localparam int HALF_SHADE_W = 7;

  // Configuration register widths and reset values.
  localparam int SIZE_W = 11;
  localparam int DAMP_W = 16;
  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 11'd480;
  localparam logic [DAMP_W-1:0] DAMPING_RST      = 16'd64881;

  // Smallest frame edge that the counters accept.
  localparam int MIN_SIZE = 3;

  // APB register map: three 32-bit registers at byte offsets 0, 4 and 8.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_FRAME_WIDTH  = 2'd0;
  localparam reg_idx_t REG_FRAME_HEIGHT = 2'd1;
  localparam reg_idx_t REG_DAMPING      = 2'd2;

  // Line buffer entry: older height, upper row, lower row.
  localparam int LINE_W = 3 * HEIGHT_W;
  typedef logic [LINE_W-1:0] line_entry_t;

  // Datapath widths.
  localparam int PART_W = HEIGHT_W + 2;        // sum of up to three heights
  localparam int DIFF_W = HEIGHT_W + 4;        // eight neighbors minus 4 * older
  localparam int PROD_W = DIFF_W + DAMP_W + 1; // signed product with damping
  localparam int FRAC_SHIFT = 18;              // Q14.26 to Q14.8, saturated to Q11.8 later
  localparam int QUOT_W = PROD_W - FRAC_SHIFT;
  localparam int MAG255_W = HEIGHT_W + 8;

endpackage : wrs_pkg

`default_nettype wire

### rtl/water_ripple_stencil_step_core.sv
// ----------------------------------------------------------------------------
// Water ripple stencil step core
// One cell per beat in raster order; emits the damped new height of every
// interior cell with its coordinates and display shade.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one cell per beat: the
//   previous-frame height, the older-frame height and a start-of-frame mark.
//   The output channel (out_valid / out_stall) carries one beat for each
//   interior cell, one row and one column behind the input; border cells
//   produce nothing.
//   Throughput: one cell per clock. The pipeline has five registered stages
//   (line buffer read, partial sums, difference, product, result); an empty
//   stage is filled even while a later one holds, so in_stall only rises when
//   every stage holds a result that the receiver has not yet taken.
//   The line buffer is one single-port-write, single-port-read memory of
//   MAX_WIDTH entries; a column that has not been written since reset reads
//   as zero through a fill count, so no clearing pass is needed.
//   Reset: the APB registers return to 640 x 480 with damping 0.99, the
//   position counters return to column 0, row 0 and the pipeline empties.
//   Write configuration over APB only when no beat is in flight; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module water_ripple_stencil_step_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // Input channel
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire wrs_pkg::height_t                 in_prev_height,
  input  wire wrs_pkg::height_t                 in_older_height,
  input  wire                                   in_start_of_frame,
  // Result channel
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output wrs_pkg::height_t                      out_new_height,
  output logic [wrs_pkg::COORD_W-1:0]           out_cell_column,
  output logic [wrs_pkg::COORD_W-1:0]           out_cell_row,
  output logic [wrs_pkg::SHADE_W-1:0]           out_shade,
  output logic [wrs_pkg::HALF_SHADE_W-1:0]      out_half_shade,
  // APB configuration port
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [wrs_pkg::APB_ADDR_W-1:0]        paddr,
  input  wire  [wrs_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [wrs_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  import wrs_pkg::*;

  // Counter and size widths.
  localparam int CW  = $clog2(MAX_WIDTH);        // column index
  localparam int RW  = $clog2(MAX_HEIGHT);       // row index
  localparam int WW  = $clog2(MAX_WIDTH + 1);    // column count up to MAX_WIDTH
  localparam int HW  = $clog2(MAX_HEIGHT + 1);   // row count up to MAX_HEIGHT
  localparam int CWX = (WW > SIZE_W) ? WW : SIZE_W;
  localparam int HWX = (HW > SIZE_W) ? HW : SIZE_W;
  localparam int CXW = (CW > COORD_W) ? CW : COORD_W;
  localparam int RXW = (RW > COORD_W) ? RW : COORD_W;

  // --------------------------------------------------------------------------
  // APB registers
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] frame_width_r;
  logic [SIZE_W-1:0] frame_height_r;
  logic [DAMP_W-1:0] damping_factor_r;
  logic              apb_wr;
  reg_idx_t          apb_idx;

  assign pready  = 1'b1;
  assign apb_wr  = psel & penable & pwrite;
  assign apb_idx = paddr[REG_IDX_W+1:2];

  // Register write decode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= FRAME_WIDTH_RST;
      frame_height_r   <= FRAME_HEIGHT_RST;
      damping_factor_r <= DAMPING_RST;
    end else if (apb_wr) begin
      unique case (apb_idx)
        REG_FRAME_WIDTH:  frame_width_r    <= pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r   <= pwdata[SIZE_W-1:0];
        REG_DAMPING:      damping_factor_r <= pwdata[DAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read decode.
  always_comb begin
    unique case (apb_idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_r);
      REG_DAMPING:      prdata = APB_DATA_W'(damping_factor_r);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Frame size, clamped to the supported range
  // --------------------------------------------------------------------------
  logic [CWX-1:0] fw_ext;
  logic [HWX-1:0] fh_ext;
  logic [CWX-1:0] fw_clamp;
  logic [HWX-1:0] fh_clamp;
  logic [WW-1:0]  width;
  logic [HW-1:0]  height;

  always_comb begin
    fw_ext = CWX'(frame_width_r);
    fh_ext = HWX'(frame_height_r);
    if (fw_ext < CWX'(MIN_SIZE)) begin
      fw_clamp = CWX'(MIN_SIZE);
    end else if (fw_ext > CWX'(MAX_WIDTH)) begin
      fw_clamp = CWX'(MAX_WIDTH);
    end else begin
      fw_clamp = fw_ext;
    end
    if (fh_ext < HWX'(MIN_SIZE)) begin
      fh_clamp = HWX'(MIN_SIZE);
    end else if (fh_ext > HWX'(MAX_HEIGHT)) begin
      fh_clamp = HWX'(MAX_HEIGHT);
    end else begin
      fh_clamp = fh_ext;
    end
  end

  assign width  = fw_clamp[WW-1:0];
  assign height = fh_clamp[HW-1:0];

  // --------------------------------------------------------------------------
  // Pipeline flow control: each stage loads when empty or when it moves on
  // --------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  logic s1_emit_r;
  logic out_free, s4_free, s3_free, s2_free, s1_free;
  logic s1_move;
  logic in_accept;

  assign out_free  = !out_valid_r || !out_stall;
  assign s4_free   = !s4_valid_r || out_free;
  assign s3_free   = !s3_valid_r || s4_free;
  assign s2_free   = !s2_valid_r || s3_free;
  // A border cell leaves stage one without needing room further on.
  assign s1_move   = s1_valid_r && (!s1_emit_r || s2_free);
  assign s1_free   = !s1_valid_r || s1_move;
  assign in_stall  = !s1_free;
  assign in_accept = in_valid && s1_free;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free)  s1_valid_r  <= in_valid;
      if (s2_free)  s2_valid_r  <= s1_move && s1_emit_r;
      if (s3_free)  s3_valid_r  <= s2_valid_r;
      if (s4_free)  s4_valid_r  <= s3_valid_r;
      if (out_free) out_valid_r <= s4_valid_r;
    end
  end

  // --------------------------------------------------------------------------
  // Position counters (stage zero, at the accept edge)
  // --------------------------------------------------------------------------
  logic [CW-1:0] column_count_r, column_count_nxt;
  logic [RW-1:0] row_count_r, row_count_nxt;
  logic [CW-1:0] col_base, col_cur;
  logic [RW-1:0] row_base, row_cur;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;
  logic          emit_cur;

  always_comb begin
    col_base = in_start_of_frame ? '0 : column_count_r;
    row_base = in_start_of_frame ? '0 : row_count_r;
    // A count beyond a shrunken frame wraps to the start.
    col_cur  = (WW'(col_base) >= width)  ? '0 : col_base;
    row_cur  = (HW'(row_base) >= height) ? '0 : row_base;
    col_inc  = WW'(col_cur) + WW'(1);
    row_inc  = HW'(row_cur) + HW'(1);
    if (col_inc >= width) begin
      column_count_nxt = '0;
      row_count_nxt    = (row_inc >= height) ? '0 : row_inc[RW-1:0];
    end else begin
      column_count_nxt = col_inc[CW-1:0];
      row_count_nxt    = row_cur;
    end
    emit_cur = (WW'(col_cur) >= WW'(2)) && (HW'(row_cur) >= HW'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
    end else if (in_accept) begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Line buffer: one entry per column holding {older, upper row, lower row}
  // --------------------------------------------------------------------------
  line_entry_t   line_mem [MAX_WIDTH];
  line_entry_t   line_rd_r;
  line_entry_t   line_wr;
  line_entry_t   fwd_data_r;
  logic          fwd_hit_r;
  logic          filled_r;
  logic [WW-1:0] fill_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  height_t       s1_prev_r;
  height_t       s1_older_r;
  line_entry_t   line_col;
  height_t       upper_rd, lower_rd, older_rd;

  // Read at the accept edge, write when the cell leaves stage one.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      line_mem[s1_col_r] <= line_wr;
    end
    if (in_accept) begin
      line_rd_r <= line_mem[col_cur];
    end
  end

  // Columns written since reset always form a prefix; the fill count marks it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (s1_move && (WW'(s1_col_r) == fill_r)) begin
      fill_r <= fill_r + WW'(1);
    end
  end

  // Stage one payload, with a bypass for a write to the column being read.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col_r   <= col_cur;
      s1_row_r   <= row_cur;
      s1_emit_r  <= emit_cur;
      s1_prev_r  <= in_prev_height;
      s1_older_r <= in_older_height;
      fwd_hit_r  <= s1_move && (s1_col_r == col_cur);
      fwd_data_r <= line_wr;
      filled_r   <= WW'(col_cur) < fill_r;
    end
  end

  always_comb begin
    if (fwd_hit_r) begin
      line_col = fwd_data_r;
    end else if (filled_r) begin
      line_col = line_rd_r;
    end else begin
      line_col = '0;
    end
    older_rd = line_col[3*HEIGHT_W-1:2*HEIGHT_W];
    upper_rd = line_col[2*HEIGHT_W-1:HEIGHT_W];
    lower_rd = line_col[HEIGHT_W-1:0];
    // Rows move up by one and the new cell becomes the lower row.
    line_wr  = {s1_older_r, lower_rd, s1_prev_r};
  end

  // --------------------------------------------------------------------------
  // 3x3 window (index 3*row+col, col 2 newest) and older center delay
  // --------------------------------------------------------------------------
  height_t window_r [9];
  height_t older_center_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) window_r[i] <= '0;
      older_center_r[0] <= '0;
      older_center_r[1] <= '0;
    end else if (s1_move) begin
      for (int k = 0; k < 3; k++) begin
        window_r[3*k]   <= window_r[3*k+1];
        window_r[3*k+1] <= window_r[3*k+2];
      end
      window_r[2]       <= upper_rd;
      window_r[5]       <= lower_rd;
      window_r[8]       <= s1_prev_r;
      older_center_r[0] <= older_center_r[1];
      older_center_r[1] <= older_rd;
    end
  end

  // --------------------------------------------------------------------------
  // Stage two: column partial sums of the shifted window
  // --------------------------------------------------------------------------
  logic signed [PART_W-1:0] left_sum_r, mid_sum_r, right_sum_r;
  height_t                  s2_older_r;
  logic [CW-1:0]            s2_col_r;
  logic [RW-1:0]            s2_row_r;

  always_ff @(posedge clk) begin
    if (s2_free && s1_move && s1_emit_r) begin
      left_sum_r  <= PART_W'(window_r[1]) + PART_W'(window_r[4]) + PART_W'(window_r[7]);
      mid_sum_r   <= PART_W'(window_r[2]) + PART_W'(window_r[8]);
      right_sum_r <= PART_W'(upper_rd) + PART_W'(lower_rd) + PART_W'(s1_prev_r);
      s2_older_r  <= older_center_r[1];
      s2_col_r    <= s1_col_r;
      s2_row_r    <= s1_row_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage three: neighbor sum minus four times the older center
  // --------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] diff_r;
  logic [CW-1:0]            s3_col_r;
  logic [RW-1:0]            s3_row_r;

  always_ff @(posedge clk) begin
    if (s3_free && s2_valid_r) begin
      diff_r   <= DIFF_W'(left_sum_r) + DIFF_W'(mid_sum_r) + DIFF_W'(right_sum_r)
                  - (DIFF_W'(s2_older_r) <<< 2);
      s3_col_r <= s2_col_r;
      s3_row_r <= s2_row_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage four: damping product, Q14.26
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_r;
  logic [CW-1:0]            s4_col_r;
  logic [RW-1:0]            s4_row_r;

  always_ff @(posedge clk) begin
    if (s4_free && s3_valid_r) begin
      prod_r   <= diff_r * $signed({1'b0, damping_factor_r});
      s4_col_r <= s3_col_r;
      s4_row_r <= s3_row_r;
    end
  end

  // --------------------------------------------------------------------------
  // Result stage: round, saturate, shade and coordinates
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [QUOT_W-1:0]   quot;
  height_t                    height_sat;
  logic [HEIGHT_W:0]          neg_ext;
  logic [HEIGHT_W-1:0]        mag;
  logic [MAG255_W-1:0]        mag255;
  logic [HEIGHT_W-1:0]        shade_raw;
  logic [SHADE_W-1:0]         shade_sat;
  logic [CXW-1:0]             col_out;
  logic [RXW-1:0]             row_out;

  always_comb begin
    // Round to nearest, ties toward plus infinity.
    prod_rnd = prod_r + (PROD_W'(1) <<< (FRAC_SHIFT - 1));
    quot     = prod_rnd[PROD_W-1:FRAC_SHIFT];
    if (quot > QUOT_W'($signed({1'b0, {(HEIGHT_W-1){1'b1}}}))) begin
      height_sat = {1'b0, {(HEIGHT_W-1){1'b1}}};
    end else if (quot < QUOT_W'($signed({1'b1, {(HEIGHT_W-1){1'b0}}}))) begin
      height_sat = {1'b1, {(HEIGHT_W-1){1'b0}}};
    end else begin
      height_sat = quot[HEIGHT_W-1:0];
    end
    // Magnitude fits 20 unsigned bits, including the most negative value.
    neg_ext   = -(HEIGHT_W+1)'(height_sat);
    mag       = height_sat[HEIGHT_W-1] ? neg_ext[HEIGHT_W-1:0] : height_sat;
    mag255    = {mag, 8'b0} - MAG255_W'(mag);
    shade_raw = mag255[MAG255_W-1:8];
    shade_sat = (shade_raw > HEIGHT_W'(255)) ? 8'd255 : shade_raw[SHADE_W-1:0];
    col_out   = CXW'(s4_col_r) - CXW'(1);
    row_out   = RXW'(s4_row_r) - RXW'(1);
  end

  always_ff @(posedge clk) begin
    if (out_free && s4_valid_r) begin
      out_new_height  <= height_sat;
      out_cell_column <= col_out[COORD_W-1:0];
      out_cell_row    <= row_out[COORD_W-1:0];
      out_shade       <= shade_sat;
      out_half_shade  <= shade_sat[SHADE_W-1:1];
    end
  end

endmodule : water_ripple_stencil_step_core

`default_nettype wire
